[hw/rtl/wsg_pkg.sv]
// Shared types and constants of the wavetable sound generator.
`timescale 1ns / 1ps

package wsg_pkg;

    localparam int WAVE_LEN  = 32;
    localparam int RES_DEPTH = 2;

    // register groups selected by port bits 3:1
    localparam logic [2:0] GRP_WAVE     = 3'd0;
    localparam logic [2:0] GRP_PERIOD   = 3'd1;
    localparam logic [2:0] GRP_LEVEL    = 3'd2;
    localparam logic [2:0] GRP_KEY      = 3'd3;
    localparam logic [2:0] GRP_WAVE_ALT = 3'd4;
    localparam logic [2:0] GRP_TEST     = 3'd5;

    // test register bits
    localparam int TEST_CNT_RESET  = 5;
    localparam int TEST_WAVE_OFF   = 6;
    localparam int TEST_SHARED_OFF = 7;

    localparam logic [7:0]  SHARED_BASE  = 8'h60;
    localparam logic [2:0]  SHARED_LO    = 3'd3;
    localparam logic [2:0]  SHARED_HI    = 3'd4;
    localparam logic [11:0] SLOW_LIMIT   = 12'd8;
    localparam logic [3:0]  LEVEL_RESET  = 4'hF;

    typedef enum logic [2:0] {
        KIND_ADDR,
        KIND_WAVE,
        KIND_PERIOD,
        KIND_LEVEL,
        KIND_KEY,
        KIND_TEST,
        KIND_NOP,
        KIND_TICK
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } cmd_t;

endpackage

[hw/rtl/wsg_fifo.sv]
// Small first-in first-out queue of words.
`timescale 1ns / 1ps

module wsg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[hw/rtl/wsg_front.sv]
// Input side: decodes each input word into a command and queues it.
`timescale 1ns / 1ps

module wsg_front #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              mode,
    input  logic [3:0]        port,
    input  logic [7:0]        data,
    input  logic              hold,
    output logic              full,
    output wsg_pkg::cmd_t     head,
    output logic              head_empty,
    input  logic              head_pop
);

    localparam int CMD_W = $bits(wsg_pkg::cmd_t);

    wsg_pkg::cmd_t    cmd_in;
    logic [CMD_W-1:0] q_data;
    logic             q_full;

    always_comb
    begin
        cmd_in.data = data;
        if (mode)
        begin
            cmd_in.kind = wsg_pkg::KIND_TICK;
        end
        else if (!port[0])
        begin
            cmd_in.kind = wsg_pkg::KIND_ADDR;
        end
        else
        begin
            case (port[3:1])
                wsg_pkg::GRP_WAVE,
                wsg_pkg::GRP_WAVE_ALT: cmd_in.kind = wsg_pkg::KIND_WAVE;
                wsg_pkg::GRP_PERIOD:   cmd_in.kind = wsg_pkg::KIND_PERIOD;
                wsg_pkg::GRP_LEVEL:    cmd_in.kind = wsg_pkg::KIND_LEVEL;
                wsg_pkg::GRP_KEY:      cmd_in.kind = wsg_pkg::KIND_KEY;
                wsg_pkg::GRP_TEST:     cmd_in.kind = wsg_pkg::KIND_TEST;
                default:               cmd_in.kind = wsg_pkg::KIND_NOP;
            endcase
        end
    end

    // refuse words while the back end sweeps its wave memory
    assign full = q_full || hold;
    assign head = wsg_pkg::cmd_t'(q_data);

    wsg_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push && !full),
        .wr_data (cmd_in),
        .full    (q_full),
        .rd_en   (head_pop),
        .rd_data (q_data),
        .empty   (head_empty)
    );

endmodule

[hw/rtl/wsg_back.sv]
// Execution side: voice registers, wave memory, tick sequencer and mixer.
`timescale 1ns / 1ps

module wsg_back #(
    parameter int NUM_VOICES = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_bit,
    input  wsg_pkg::cmd_t       cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output logic                clearing,
    output logic signed [15:0]  sample_sum,
    output logic                empty,
    input  logic                pop
);

    localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int DEPTH = NUM_VOICES * wsg_pkg::WAVE_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [7:0]    NV8    = 8'(NUM_VOICES);
    localparam logic [VW-1:0] LAST_V = VW'(NUM_VOICES - 1);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_WAVE2 = 7'b0001000,
        S_STEP  = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    wsg_pkg::cmd_t        cmd_reg, cmd_next;
    logic [7:0]           addr_reg, addr_next;
    logic [7:0]           tbits_reg, tbits_next;
    logic                 plus_reg, plus_next;
    logic [11:0]          period_reg [NUM_VOICES];
    logic [11:0]          period_next [NUM_VOICES];
    logic [3:0]           level_reg [NUM_VOICES];
    logic [3:0]           level_next [NUM_VOICES];
    logic [4:0]           phase_reg [NUM_VOICES];
    logic [4:0]           phase_next [NUM_VOICES];
    logic [11:0]          div_reg [NUM_VOICES];
    logic [11:0]          div_next [NUM_VOICES];
    logic [NUM_VOICES-1:0] key_reg, key_next;
    logic signed [12:0]   held_reg [NUM_VOICES];
    logic signed [12:0]   held_next [NUM_VOICES];
    logic [VW-1:0]        voice_reg, voice_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic                 go_reg, go_next;
    logic [7:0]           rd_data_reg;
    logic [7:0]           mem [DEPTH];

    logic                 mem_we;
    logic [AW-1:0]        mem_wa, mem_ra;
    logic [7:0]           mem_wd;
    logic                 res_push, res_full;
    logic                 step_active;
    logic [4:0]           phase_step;
    logic [2:0]           wave_voice;
    logic [VW-1:0]        pch, lch;
    logic signed [12:0]   s_ext, l_ext, prod;
    logic signed [12:0]   held_val;
    logic signed [15:0]   sum;

    assign clearing   = (state_reg == S_CLEAR);
    assign wave_voice = addr_reg[7:5];
    assign pch        = VW'(addr_reg[7:1]);
    assign lch        = VW'(addr_reg[2:0]);

    // phase the current voice moves to on this tick
    assign step_active = (period_reg[voice_reg] > wsg_pkg::SLOW_LIMIT);
    assign phase_step  = (step_active && (div_reg[voice_reg] == '0))
                         ? phase_reg[voice_reg] + 5'd1 : phase_reg[voice_reg];
    assign mem_ra      = AW'({voice_reg, phase_step});

    // sample times level, floored to a sixteenth, then scaled by 32
    assign s_ext    = {{5{rd_data_reg[7]}}, rd_data_reg};
    assign l_ext    = {9'b0, level_reg[voice_reg]};
    assign prod     = s_ext * l_ext;
    assign held_val = {prod[11:4], 5'b0};

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            sum = sum + {{3{held_reg[i][12]}}, held_reg[i]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        addr_next  = addr_reg;
        tbits_next = tbits_reg;
        plus_next  = plus_reg;
        key_next   = key_reg;
        voice_next = voice_reg;
        clr_next   = clr_reg;
        go_next    = go_reg;
        for (int i = 0; i < NUM_VOICES; i++)
        begin
            period_next[i] = period_reg[i];
            level_next[i]  = level_reg[i];
            phase_next[i]  = phase_reg[i];
            div_next[i]    = div_reg[i];
            held_next[i]   = held_reg[i];
        end
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = cmd_reg.data;
        cmd_pop  = 1'b0;
        res_push = 1'b0;

        if (cfg_we)
        begin
            plus_next = cfg_bit;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_A)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (cmd_reg.kind)
                    wsg_pkg::KIND_ADDR:
                    begin
                        addr_next = cmd_reg.data;
                    end
                    wsg_pkg::KIND_WAVE:
                    begin
                        if (!tbits_reg[wsg_pkg::TEST_WAVE_OFF])
                        begin
                            if (!plus_reg && (addr_reg >= wsg_pkg::SHARED_BASE))
                            begin
                                // shared table: write the lower voice now, the upper next
                                if (!tbits_reg[wsg_pkg::TEST_SHARED_OFF])
                                begin
                                    mem_we = ({5'b0, wsg_pkg::SHARED_LO} < NV8);
                                    mem_wa = AW'({wsg_pkg::SHARED_LO, addr_reg[4:0]});
                                    state_next = S_WAVE2;
                                end
                            end
                            else
                            begin
                                mem_we = ({5'b0, wave_voice} < NV8);
                                mem_wa = AW'({wave_voice, addr_reg[4:0]});
                            end
                        end
                    end
                    wsg_pkg::KIND_PERIOD:
                    begin
                        if ({1'b0, addr_reg[7:1]} < NV8)
                        begin
                            if (tbits_reg[wsg_pkg::TEST_CNT_RESET])
                            begin
                                phase_next[pch] = '0;
                                div_next[pch]   = '0;
                            end
                            else if (period_reg[pch] <= wsg_pkg::SLOW_LIMIT)
                            begin
                                div_next[pch] = '0;
                            end
                            if (addr_reg[0])
                            begin
                                period_next[pch] = {cmd_reg.data[3:0], period_reg[pch][7:0]};
                            end
                            else
                            begin
                                period_next[pch] = {period_reg[pch][11:8], cmd_reg.data};
                            end
                        end
                    end
                    wsg_pkg::KIND_LEVEL:
                    begin
                        if ({5'b0, addr_reg[2:0]} < NV8)
                        begin
                            level_next[lch] = cmd_reg.data[3:0];
                        end
                    end
                    wsg_pkg::KIND_KEY:
                    begin
                        for (int i = 0; i < NUM_VOICES; i++)
                        begin
                            key_next[i] = cmd_reg.data[i];
                        end
                    end
                    wsg_pkg::KIND_TEST:
                    begin
                        tbits_next = cmd_reg.data;
                    end
                    wsg_pkg::KIND_TICK:
                    begin
                        voice_next = '0;
                        state_next = S_STEP;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_WAVE2:
            begin
                mem_we     = ({5'b0, wsg_pkg::SHARED_HI} < NV8);
                mem_wa     = AW'({wsg_pkg::SHARED_HI, addr_reg[4:0]});
                state_next = S_DONE;
            end
            S_STEP:
            begin
                if (step_active)
                begin
                    phase_next[voice_reg] = phase_step;
                    if (div_reg[voice_reg] == '0)
                    begin
                        div_next[voice_reg] = period_reg[voice_reg];
                    end
                    else
                    begin
                        div_next[voice_reg] = div_reg[voice_reg] - 12'd1;
                    end
                end
                go_next    = step_active && key_reg[voice_reg];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (go_reg)
                begin
                    held_next[voice_reg] = held_val;
                end
                if (voice_reg == LAST_V)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    voice_next = voice_reg + VW'(1);
                    state_next = S_STEP;
                end
            end
            S_DONE:
            begin
                // hold until the result queue has room
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            addr_reg  <= '0;
            tbits_reg <= '0;
            plus_reg  <= 1'b0;
            key_reg   <= '0;
            voice_reg <= '0;
            clr_reg   <= '0;
            go_reg    <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                period_reg[i] <= '0;
                level_reg[i]  <= wsg_pkg::LEVEL_RESET;
                phase_reg[i]  <= '0;
                div_reg[i]    <= '0;
                held_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            tbits_reg <= tbits_next;
            plus_reg  <= plus_next;
            key_reg   <= key_next;
            voice_reg <= voice_next;
            clr_reg   <= clr_next;
            go_reg    <= go_next;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                period_reg[i] <= period_next[i];
                level_reg[i]  <= level_next[i];
                phase_reg[i]  <= phase_next[i];
                div_reg[i]    <= div_next[i];
                held_reg[i]   <= held_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    wsg_fifo #(
        .WIDTH (16),
        .DEPTH (wsg_pkg::RES_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (sum),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (sample_sum),
        .empty   (empty)
    );

endmodule

[hw/rtl/wavetable_sound_generator.sv]
// Wavetable sound generator: multi-voice bus-programmed synthesiser, one sample per input word.
//
// Input channel: a word (mode, port, data) is taken when push is high and full is low.
//   mode 1 is a sample tick; mode 0 is a bus write (even port latches the address,
//   odd port writes the register group picked by port bits 3:1).
// Result channel: every input word yields one sample_sum, the sum of all voices'
//   held outputs; it is shown while empty is low and taken when pop is high.
// Configuration: cfg_data selects the plus variant (separate tables for voices 3, 4);
//   cfg_ready is always high, and writes belong to quiet periods only.
// Sequencing: in the back end a bus write passes S_IDLE, S_EXEC and S_DONE (a shared-table
//   write also S_WAVE2), a tick passes S_IDLE, S_EXEC, then S_STEP and S_MUL for each voice
//   and S_DONE; S_STEP serves the voice's divider and the single wave memory read port,
//   S_MUL the level multiply. The sample is pushed into the result queue in S_DONE.
// Reset: all voice state returns to its power-up values and the wave memory is
//   swept to zero, one entry a cycle, NUM_VOICES*32 entries in all; full stays high meanwhile.
// Stalls: a command queue of CMD_DEPTH words decouples the input from execution and a
//   two-word result queue holds finished samples; when pop stays low the back end
//   waits and full rises once the command queue fills.
`timescale 1ns / 1ps

module wavetable_sound_generator #(
    parameter int NUM_VOICES = 5,
    parameter int CMD_DEPTH  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               mode,
    input  logic [3:0]         port,
    input  logic [7:0]         data,
    output logic               empty,
    input  logic               pop,
    output logic signed [15:0] sample_sum,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);

    wsg_pkg::cmd_t head;
    logic          head_empty;
    logic          head_pop;
    logic          clearing;

    assign cfg_ready = 1'b1;

    wsg_front #(
        .DEPTH (CMD_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .mode       (mode),
        .port       (port),
        .data       (data),
        .hold       (clearing),
        .full       (full),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop)
    );

    wsg_back #(
        .NUM_VOICES (NUM_VOICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_bit      (cfg_data),
        .cmd          (head),
        .cmd_empty    (head_empty),
        .cmd_pop      (head_pop),
        .clearing     (clearing),
        .sample_sum   (sample_sum),
        .empty        (empty),
        .pop          (pop)
    );

endmodule
